@@ design/spd_pkg.sv @@
// Package for the sensor packet deframer.
// Holds buffer sizing, header layout, status codes and configuration indexes.
// Used by design/sensor_packet_deframer.sv.
package spd_pkg;

    // Receive buffer size in bytes; it bounds the byte position.
    localparam int BUFFER_BYTES = 64;
    // Start code, address, type and length take nine bytes ahead of the payload.
    localparam int HEADER_BYTES = 9;
    localparam int POS_W        = $clog2(BUFFER_BYTES);
    localparam int POS_LIMIT    = BUFFER_BYTES - HEADER_BYTES;

    // Result status codes.
    localparam logic [2:0] ST_PAYLOAD  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_AWAITED  = 3'd4;

    // Item kinds.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AWAIT_TICKS = 2'd2;

    // Register reset values.
    localparam logic [15:0] START_CODE_RST  = 16'hEF01;
    localparam logic [15:0] IDLE_LIMIT_RST  = 16'd1000;
    localparam logic [23:0] AWAIT_TICKS_RST = 24'd0;

endpackage

@@ design/sensor_packet_deframer.sv @@
// Sensor packet deframer: hunts a start code, collects the header, streams payload.
// Depends on spd_pkg for sizing, status codes and configuration indexes.
// Each item is a received byte or a millisecond tick; at most one result per item.

// The block takes one item in every clock cycle and places its result, if any,
// in an output register. All header and payload decoding is done by a single
// level of logic between the packet state registers and that register, so the
// rate is set only by the output side: an item is refused only while a result
// waits in the output register and the consumer stalls. Configuration writes
// take effect at the next edge; there is no clearing pass after reset.
module sensor_packet_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input item channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [7:0]                    i_rx_byte,
    // Result item channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_payload_byte,
    output logic [5:0]                    o_payload_index,
    output logic [7:0]                    o_pkt_type,
    output logic [15:0]                   o_pkt_length,
    output logic [31:0]                   o_dev_address
);
    import spd_pkg::*;

    // Configuration registers.
    logic [15:0] r_start_code;
    logic [15:0] r_idle_limit;
    logic [23:0] r_await_ticks;

    // Packet state.
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [7:0]       r_type,    n_type;
    logic [15:0]      r_len,     n_len;
    logic [31:0]      r_addr,    n_addr;
    logic [15:0]      r_idle,    n_idle;
    logic [23:0]      r_elapsed, n_elapsed;

    // Output register.
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [7:0]  r_byte;
    logic [5:0]  r_index;
    logic [7:0]  r_out_type;
    logic [15:0] r_out_len;
    logic [31:0] r_out_addr;

    // Result of the current item.
    logic        res_valid;
    logic [2:0]  res_status;
    logic [7:0]  res_byte;
    logic [5:0]  res_index;
    logic        restart;

    logic             in_acc;
    logic             out_acc;
    logic             resync;
    logic [POS_W:0]   pos_inc;
    logic             overflow;
    logic [15:0]      data_count;
    logic             complete;
    logic [POS_W-1:0] data_pos;

    // An item can enter unless a result is held by a stalled consumer.
    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = r_out_valid & ~i_stall;

    assign resync     = (r_await_ticks != 24'd0);
    assign pos_inc    = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
    assign overflow   = (pos_inc >= (POS_W+1)'(POS_LIMIT));
    assign data_count = 16'(r_pos) - 16'(HEADER_BYTES - 1);
    assign complete   = (data_count == r_len);
    assign data_pos   = r_pos - POS_W'(HEADER_BYTES);

    // Decode one item against the packet state.
    always_comb begin
        n_pos      = r_pos;
        n_type     = r_type;
        n_len      = r_len;
        n_addr     = r_addr;
        n_idle     = r_idle;
        n_elapsed  = r_elapsed;
        res_valid  = 1'b0;
        res_status = ST_PAYLOAD;
        res_byte   = 8'd0;
        res_index  = 6'd0;
        restart    = 1'b0;

        if (i_func == FUNC_TICK) begin
            // Ticks count idle time; bytes do not clear the idle count unless they end a packet.
            if (r_idle != 16'hFFFF) begin
                n_idle = r_idle + 16'd1;
            end
            if (resync) begin
                if (r_elapsed >= r_await_ticks) begin
                    res_valid  = 1'b1;
                    res_status = ST_AWAITED;
                    restart    = 1'b1;
                end else begin
                    n_elapsed = r_elapsed + 24'd1;
                end
            end else if (n_idle >= r_idle_limit) begin
                res_valid  = 1'b1;
                res_status = ST_TIMEOUT;
                restart    = 1'b1;
            end
        end else begin
            priority if (r_pos == POS_W'(0)) begin
                // Hunt for the high byte of the start code.
                if (i_rx_byte == r_start_code[15:8]) begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end else if (r_pos == POS_W'(1)) begin
                if (i_rx_byte != r_start_code[7:0]) begin
                    // Bad start code: silent restart in resync mode.
                    if (resync) begin
                        n_pos = '0;
                    end else begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD;
                        restart    = 1'b1;
                    end
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end else if (r_pos <= POS_W'(5)) begin
                n_addr = {r_addr[23:0], i_rx_byte};
                n_pos  = pos_inc[POS_W-1:0];
            end else if (r_pos == POS_W'(6)) begin
                n_type = i_rx_byte;
                n_pos  = pos_inc[POS_W-1:0];
            end else if (r_pos == POS_W'(7)) begin
                n_len = {i_rx_byte, 8'd0};
                n_pos = pos_inc[POS_W-1:0];
            end else if (r_pos == POS_W'(8)) begin
                n_len = {r_len[15:8], i_rx_byte};
                n_pos = pos_inc[POS_W-1:0];
            end else begin
                // Payload byte; the last counted byte completes the packet.
                res_valid = 1'b1;
                res_byte  = i_rx_byte;
                res_index = 6'(data_pos);
                if (complete) begin
                    res_status = ST_COMPLETE;
                    restart    = 1'b1;
                end else begin
                    res_status = ST_PAYLOAD;
                    n_pos      = pos_inc[POS_W-1:0];
                end
            end

            // Buffer overflow overrides any payload result after the advance.
            if (!restart && (n_pos != r_pos) && overflow) begin
                res_valid  = 1'b1;
                res_status = ST_BAD;
                res_byte   = 8'd0;
                res_index  = 6'd0;
                restart    = 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= START_CODE_RST;
            r_idle_limit  <= IDLE_LIMIT_RST;
            r_await_ticks <= AWAIT_TICKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_START_CODE) begin
                r_start_code <= i_cfg_data[15:0];
            end
            if (i_cfg_index == CFG_IDLE_LIMIT) begin
                r_idle_limit <= i_cfg_data[15:0];
            end
            if (i_cfg_index == CFG_AWAIT_TICKS) begin
                r_await_ticks <= i_cfg_data[23:0];
            end
        end
    end

    // Packet state update; any packet end returns everything to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_type    <= '0;
            r_len     <= '0;
            r_addr    <= '0;
            r_idle    <= '0;
            r_elapsed <= '0;
        end else if (in_acc) begin
            if (restart) begin
                r_pos     <= '0;
                r_type    <= '0;
                r_len     <= '0;
                r_addr    <= '0;
                r_idle    <= '0;
                r_elapsed <= '0;
            end else begin
                r_pos     <= n_pos;
                r_type    <= n_type;
                r_len     <= n_len;
                r_addr    <= n_addr;
                r_idle    <= n_idle;
                r_elapsed <= n_elapsed;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; reports the header fields as updated by this item.
    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_status   <= res_status;
            r_byte     <= res_byte;
            r_index    <= res_index;
            r_out_type <= n_type;
            r_out_len  <= n_len;
            r_out_addr <= n_addr;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_payload_byte  = r_byte;
    assign o_payload_index = r_index;
    assign o_pkt_type      = r_out_type;
    assign o_pkt_length    = r_out_len;
    assign o_dev_address   = r_out_addr;

`ifndef SYNTHESIS
    // The byte position never reaches the overflow point.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pos) < POS_LIMIT))
        else $error("byte position beyond buffer limit");

    // A packet-ending result leaves the deframer hunting with cleared state.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_valid && (res_status != ST_PAYLOAD))
        |=> (r_pos == '0 && r_idle == 16'd0 && r_elapsed == 24'd0 && r_addr == 32'd0))
        else $error("packet end did not restart state");

    // Status results without payload carry a zero byte and index.
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_TIMEOUT || r_status == ST_BAD
                         || r_status == ST_AWAITED))
        |-> (r_byte == 8'd0 && r_index == 6'd0))
        else $error("status result carries payload");

    // A new result is only produced when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_status)))
        else $error("held result was overwritten");
`endif

endmodule

@@ test/sensor_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sensor_packet_deframer: byte and tick items in directed
// and random packets, predicted per item and compared field by field with each result.
// Depends on spd_pkg and on design/sensor_packet_deframer.sv.
module sensor_packet_deframer_tb;
    import spd_pkg::*;

    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int LONG_HOLD_CYCLES = 50;
    localparam int DRAIN_CYCLES     = 4;
    // Longest length that still completes before the buffer overflows: the last
    // byte sits at position length + 8, which must stay below the overflow point.
    localparam int MAX_PAYLOAD      = BUFFER_BYTES - 2 * HEADER_BYTES;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic [7:0]  pkt_type;
        logic [15:0] pkt_length;
        logic [31:0] dev_address;
    } frame_result_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_START_CODE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  i_func      = FUNC_BYTE;
    logic [7:0]            i_rx_byte   = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [2:0]            o_status;
    logic [7:0]            o_payload_byte;
    logic [5:0]            o_payload_index;
    logic [7:0]            o_pkt_type;
    logic [15:0]           o_pkt_length;
    logic [31:0]           o_dev_address;

    // Predicted deframer state and its copy of the registers.
    logic [7:0]  byte_pos       = '0;
    logic [7:0]  type_byte      = '0;
    logic [15:0] len_field      = '0;
    logic [31:0] addr_word      = '0;
    logic [15:0] idle_ticks     = '0;
    logic [23:0] elapsed_ticks  = '0;
    logic [15:0] start_code_cfg = START_CODE_RST;
    logic [15:0] idle_limit_cfg = IDLE_LIMIT_RST;
    logic [23:0] await_cfg      = AWAIT_TICKS_RST;

    rx_item_t      rx_items_q[$];
    frame_result_t pending_results[$];

    int   items_queued = 0;
    int   results_seen = 0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   next_hold_at = 150;
    logic calm         = 1'b0;

    sensor_packet_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_pkt_type      (o_pkt_type),
        .o_pkt_length    (o_pkt_length),
        .o_dev_address   (o_dev_address)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Results carry the header fields collected so far in the packet.
    task automatic record_result(input logic [2:0] status, input logic [7:0] data,
                                 input logic [5:0] index);
        frame_result_t r;
        r = '{status, data, index, type_byte, len_field, addr_word};
        pending_results.push_back(r);
    endtask

    function automatic void clear_packet();
        byte_pos      = '0;
        type_byte     = '0;
        len_field     = '0;
        addr_word     = '0;
        idle_ticks    = '0;
        elapsed_ticks = '0;
    endfunction

    // Advance the predicted deframer by one accepted item.
    task automatic deframe_item(input logic func, input logic [7:0] rx);
        logic       payload_seen;
        logic       consumed;
        logic [5:0] data_idx;
        payload_seen = 1'b0;
        consumed     = 1'b0;
        data_idx     = '0;
        if (func == FUNC_TICK) begin
            if (idle_ticks != 16'hFFFF) idle_ticks++;
            if (await_cfg != '0) begin
                // Resync mode: only the overall deadline ends a packet on ticks.
                if (elapsed_ticks >= await_cfg) begin
                    record_result(ST_AWAITED, '0, '0);
                    clear_packet();
                end else begin
                    elapsed_ticks++;
                end
            end else if (idle_ticks >= idle_limit_cfg) begin
                record_result(ST_TIMEOUT, '0, '0);
                clear_packet();
            end
        end else begin
            case (byte_pos)
                8'd0: consumed = (rx != start_code_cfg[15:8]);
                8'd1: begin
                    if (rx != start_code_cfg[7:0]) begin
                        consumed = 1'b1;
                        if (await_cfg != '0) begin
                            byte_pos = '0;
                        end else begin
                            record_result(ST_BAD, '0, '0);
                            clear_packet();
                        end
                    end
                end
                8'd2, 8'd3, 8'd4, 8'd5: addr_word = {addr_word[23:0], rx};
                8'd6: type_byte = rx;
                8'd7: len_field = {rx, 8'h00};
                8'd8: len_field[7:0] = rx;
                default: begin
                    data_idx = 6'(int'(byte_pos) - HEADER_BYTES);
                    if (int'(byte_pos) - (HEADER_BYTES - 1) == int'(len_field)) begin
                        record_result(ST_COMPLETE, rx, data_idx);
                        clear_packet();
                        consumed = 1'b1;
                    end else begin
                        payload_seen = 1'b1;
                    end
                end
            endcase
            if (!consumed) begin
                byte_pos++;
                // Overflow wins over a plain payload byte.
                if (int'(byte_pos) + HEADER_BYTES >= BUFFER_BYTES) begin
                    record_result(ST_BAD, '0, '0);
                    clear_packet();
                end else if (payload_seen) begin
                    record_result(ST_PAYLOAD, rx, data_idx);
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_item(input logic func, input logic [7:0] rx);
        rx_items_q.push_back('{func, rx});
        items_queued++;
    endtask

    // A byte, sometimes preceded by a tick.
    task automatic queue_byte(input logic [7:0] rx, input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct) queue_item(FUNC_TICK, 8'($urandom));
        queue_item(FUNC_BYTE, rx);
    endtask

    task automatic queue_header(input logic [31:0] addr, input logic [7:0] kind,
                                input logic [15:0] len, input int tick_pct);
        queue_byte(start_code_cfg[15:8], tick_pct);
        queue_byte(start_code_cfg[7:0], tick_pct);
        for (int i = 3; i >= 0; i--) queue_byte(addr[8*i +: 8], tick_pct);
        queue_byte(kind, tick_pct);
        queue_byte(len[15:8], tick_pct);
        queue_byte(len[7:0], tick_pct);
    endtask

    // Mostly well-formed packets, the rest noise, bad start codes and cut-off packets.
    task automatic queue_segment(input int tick_pct);
        int          kind;
        int          count;
        logic [15:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            case ($urandom_range(0, 19))
                0:       len = '0;
                1:       len = 16'hFFFF;
                2:       len = 16'(MAX_PAYLOAD);
                3:       len = 16'(MAX_PAYLOAD + 1);
                4:       len = 16'($urandom_range(MAX_PAYLOAD + 2, 16'hFFFE));
                default: len = 16'($urandom_range(1, 10));
            endcase
            count = (len >= 1 && len <= MAX_PAYLOAD) ? int'(len) : MAX_PAYLOAD;
            queue_header($urandom, 8'($urandom), len, tick_pct);
            repeat (count) queue_byte(8'($urandom), tick_pct);
        end else if (kind < 78) begin
            queue_byte(start_code_cfg[15:8], tick_pct);
            queue_byte(start_code_cfg[7:0] ^ 8'($urandom_range(1, 255)), tick_pct);
        end else if (kind < 86) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 0);
        end else if (kind < 93) begin
            repeat ($urandom_range(1, 6)) queue_item(FUNC_TICK, 8'($urandom));
        end else begin
            queue_byte(start_code_cfg[15:8], tick_pct);
            queue_byte(start_code_cfg[7:0], tick_pct);
            repeat ($urandom_range(0, 6)) queue_byte(8'($urandom), tick_pct);
        end
    endtask

    task automatic fill_phase(input int count, input int tick_pct);
        int target;
        target = items_queued + count;
        while (items_queued < target) queue_segment(tick_pct);
    endtask

    // Everything sent and every result back, then a drain wait for items that give no result.
    task automatic wait_idle();
        @(negedge i_clk);
        while (rx_items_q.size() != 0 || i_valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [15:0] code, input logic [15:0] idle,
                                input logic [23:0] deadline);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_CODE;
        i_cfg_data  <= {8'h00, code};
        @(posedge i_clk);
        i_cfg_index <= CFG_IDLE_LIMIT;
        i_cfg_data  <= {8'h00, idle};
        @(posedge i_clk);
        i_cfg_index <= CFG_AWAIT_TICKS;
        i_cfg_data  <= deadline;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        start_code_cfg = code;
        idle_limit_cfg = idle;
        await_cfg      = deadline;
    endtask

    // Item driver: predicts each accepted item, then offers the next one or a gap.
    always @(posedge i_clk) begin
        rx_item_t item;
        if (i_valid && !o_stall) deframe_item(i_func, i_rx_byte);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 2);
                i_valid <= 1'b0;
            end else if (rx_items_q.size() != 0) begin
                item = rx_items_q.pop_front();
                i_valid   <= 1'b1;
                i_func    <= item.func;
                i_rx_byte <= item.rx_byte;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted result and drives the receiver stall.
    always @(posedge i_clk) begin
        frame_result_t want;
        if (o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status 0x%0h", o_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.status), 32'(o_status));
                compare_field("payload_byte", 32'(want.payload_byte),
                              32'(o_payload_byte));
                compare_field("payload_index", 32'(want.payload_index),
                              32'(o_payload_index));
                compare_field("pkt_type", 32'(want.pkt_type), 32'(o_pkt_type));
                compare_field("pkt_length", 32'(want.pkt_length), 32'(o_pkt_length));
                compare_field("dev_address", want.dev_address, o_dev_address);
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!calm && hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!calm && results_seen >= next_hold_at) begin
            // Long hold-off so the output fills and the input backs up.
            hold_left    = LONG_HOLD_CYCLES - 1;
            next_hold_at = next_hold_at + 700;
            i_stall <= 1'b1;
        end else if (!calm && stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("sensor_packet_deframer regression: fail");
            $finish;
        end
    end

    // Stimulus phases, each started from an idle block with fresh register values.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items on the reset register values: tick, dropped bytes, bad
        // start code, a one-byte packet and a two-byte packet.
        queue_item(FUNC_TICK, 8'hFF);
        queue_item(FUNC_BYTE, 8'h00);
        queue_item(FUNC_BYTE, 8'hFF);
        queue_item(FUNC_BYTE, START_CODE_RST[15:8]);
        queue_item(FUNC_BYTE, 8'h00);
        queue_header(32'hFF00A55A, 8'hFF, 16'h0001, 0);
        queue_item(FUNC_BYTE, 8'hFF);
        queue_header(32'h00000000, 8'h00, 16'h0002, 0);
        queue_item(FUNC_BYTE, 8'h00);
        queue_item(FUNC_BYTE, 8'hFF);
        wait_idle();

        write_config(START_CODE_RST, IDLE_LIMIT_RST, AWAIT_TICKS_RST);
        fill_phase(350, 3);
        wait_idle();

        // Idle limit of one: every tick times out.
        write_config(16'($urandom), 16'd1, '0);
        fill_phase(150, 5);
        wait_idle();

        write_config(16'($urandom), 16'($urandom_range(2, 8)), '0);
        fill_phase(250, 6);
        wait_idle();

        // Resync mode with a short deadline: silent restart on a bad start code,
        // then enough ticks to reach the deadline.
        write_config(16'h0000, 16'hFFFF, 24'($urandom_range(1, 5)));
        queue_item(FUNC_BYTE, 8'h00);
        queue_item(FUNC_BYTE, 8'h5A);
        repeat (7) queue_item(FUNC_TICK, 8'($urandom));
        fill_phase(300, 8);
        wait_idle();

        write_config(16'hFFFF, 16'd2, 24'hFFFFFF);
        fill_phase(200, 5);
        wait_idle();

        // Closing stretch without any idling on either side.
        calm = 1'b1;
        write_config(16'($urandom), 16'($urandom_range(3, 40)), '0);
        fill_phase(300, 4);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("sensor_packet_deframer regression: pass");
        end else begin
            $display("sensor_packet_deframer regression: fail");
        end
        $finish;
    end

endmodule
